// File: sv/fssm_pkg.sv
package fssm_pkg;

  // Flash layout
  localparam int RECORD_BYTES     = 1024;
  localparam int SLOTS_PER_MIRROR = 4;
  localparam int MIRRORS          = 2;
  localparam int KEY_LEN          = 7;

  localparam int BYTE_W = $clog2(RECORD_BYTES);
  localparam int POS_W  = (SLOTS_PER_MIRROR > 1) ? $clog2(SLOTS_PER_MIRROR) : 1;
  localparam int MIR_W  = (MIRRORS > 1) ? $clog2(MIRRORS) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_SCAN_BYTE = 2'd0,
    MODE_SCAN_DONE = 2'd1,
    MODE_SAVE      = 2'd2,
    MODE_VERIFY    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_CHECKED = 3'd0,
    ACT_ERASE   = 3'd1,
    ACT_PROGRAM = 3'd2,
    ACT_SAVED   = 3'd3,
    ACT_FAILED  = 3'd4,
    ACT_READY   = 3'd5
  } action_t;

  typedef logic [0:0] mirror_f_t;
  typedef logic [1:0] position_f_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       program_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        slot_valid;
    mirror_f_t   mirror;
    position_f_t position;
    logic [15:0] serial;
    logic        last;
  } out_item_t;

  // One queued command: one or two results
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      pair;
  } cmd_t;

endpackage

// File: sv/fssm_front.sv
module fssm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  fssm_pkg::in_item_t item,
  input  logic               full,
  output logic               push,
  output fssm_pkg::cmd_t     cmd
);

  localparam int BW = fssm_pkg::BYTE_W;
  localparam int PW = fssm_pkg::POS_W;
  localparam int MW = fssm_pkg::MIR_W;

  localparam logic [BW-1:0] KEY_END    = BW'(fssm_pkg::KEY_LEN);
  localparam logic [BW-1:0] SUM_END    = BW'(fssm_pkg::RECORD_BYTES - 2);
  localparam logic [BW-1:0] SERIAL_HI  = BW'(fssm_pkg::RECORD_BYTES - 4);
  localparam logic [BW-1:0] SERIAL_LO  = BW'(fssm_pkg::RECORD_BYTES - 3);
  localparam logic [BW-1:0] CHECK_HI   = BW'(fssm_pkg::RECORD_BYTES - 2);
  localparam logic [BW-1:0] LAST_BYTE  = BW'(fssm_pkg::RECORD_BYTES - 1);
  localparam logic [PW-1:0] LAST_POS   = PW'(fssm_pkg::SLOTS_PER_MIRROR - 1);
  localparam logic [MW-1:0] LAST_MIR   = MW'(fssm_pkg::MIRRORS - 1);

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_FIRST  = 2'd1,
    PEND_RETRY  = 2'd2,
    PEND_FORMAT = 2'd3
  } pend_t;

  logic [BW-1:0] byte_count, byte_count_next;
  logic [15:0]   running_sum, running_sum_next;
  logic          key_match, key_match_next;
  logic [15:0]   serial_read, serial_read_next;
  logic [15:0]   checksum_read, checksum_read_next;
  logic [PW-1:0] scan_pos, scan_pos_next;
  logic [MW-1:0] scan_mir, scan_mir_next;
  logic          scan_done, scan_done_next;
  logic          any_found, any_found_next;
  logic [MW-1:0] cur_mirror, cur_mirror_next;
  logic [PW-1:0] cur_position, cur_position_next;
  logic [15:0]   cur_serial, cur_serial_next;
  pend_t         pending, pending_next;
  logic [MW-1:0] target_mirror, target_mirror_next;
  logic [PW-1:0] target_position, target_position_next;

  logic          accept;
  logic          slot_ok;
  logic [15:0]   serial_diff;
  logic [15:0]   serial_inc;
  logic [MW-1:0] nm;
  logic [PW-1:0] np;

  function automatic logic [7:0] key_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h43;
      3'd1:    b = 8'h4F;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h46;
      3'd4:    b = 8'h49;
      3'd5:    b = 8'h47;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic fssm_pkg::out_item_t mk(input fssm_pkg::action_t act, input logic ok,
                                             input logic [MW-1:0] mir,
                                             input logic [PW-1:0] pos,
                                             input logic [15:0] ser, input logic fin);
    fssm_pkg::out_item_t r;
    r.action     = act;
    r.slot_valid = ok;
    r.mirror     = fssm_pkg::mirror_f_t'(mir);
    r.position   = fssm_pkg::position_f_t'(pos);
    r.serial     = ser;
    r.last       = fin;
    return r;
  endfunction

  assign item_stall  = full;
  assign accept      = item_valid && !full;
  assign serial_inc  = cur_serial + 16'd1;
  assign slot_ok     = key_match && (running_sum == {checksum_read[15:8], item.data_byte});
  assign serial_diff = cur_serial - serial_read;
  // Rotate mirror first; step the position when the mirror wraps
  assign nm = (cur_mirror == LAST_MIR) ? '0 : cur_mirror + 1'b1;
  assign np = (nm != '0) ? cur_position : ((cur_position == LAST_POS) ? '0 : cur_position + 1'b1);

  always_comb begin
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    key_match_next       = key_match;
    serial_read_next     = serial_read;
    checksum_read_next   = checksum_read;
    scan_pos_next        = scan_pos;
    scan_mir_next        = scan_mir;
    scan_done_next       = scan_done;
    any_found_next       = any_found;
    cur_mirror_next      = cur_mirror;
    cur_position_next    = cur_position;
    cur_serial_next      = cur_serial;
    pending_next         = pending;
    target_mirror_next   = target_mirror;
    target_position_next = target_position;
    push                 = 1'b0;
    cmd                  = '0;

    if (accept) begin
      case (fssm_pkg::mode_t'(item.mode))
        fssm_pkg::MODE_SCAN_BYTE: begin
          if (!scan_done) begin
            if (byte_count < KEY_END && item.data_byte != key_byte(byte_count[2:0])) begin
              key_match_next = 1'b0;
            end
            if (byte_count < SUM_END) begin
              running_sum_next = running_sum + 16'(item.data_byte);
            end
            if (byte_count == SERIAL_HI) serial_read_next[15:8] = item.data_byte;
            if (byte_count == SERIAL_LO) serial_read_next[7:0] = item.data_byte;
            if (byte_count == CHECK_HI) checksum_read_next[15:8] = item.data_byte;
            if (byte_count != LAST_BYTE) begin
              byte_count_next = byte_count + 1'b1;
            end else begin
              push      = 1'b1;
              cmd.first = mk(fssm_pkg::ACT_CHECKED, slot_ok, scan_mir, scan_pos,
                             serial_read, 1'b1);
              // Newer serial wins under wraparound; earlier slot keeps a tie
              if (slot_ok) begin
                if (!any_found || serial_diff[15]) begin
                  cur_mirror_next   = scan_mir;
                  cur_position_next = scan_pos;
                  cur_serial_next   = serial_read;
                end
                any_found_next = 1'b1;
              end
              if (scan_pos == LAST_POS) begin
                scan_pos_next = '0;
                if (scan_mir == LAST_MIR) begin
                  scan_done_next = 1'b1;
                end else begin
                  scan_mir_next = scan_mir + 1'b1;
                end
              end else begin
                scan_pos_next = scan_pos + 1'b1;
              end
              byte_count_next    = '0;
              running_sum_next   = '0;
              key_match_next     = 1'b1;
              serial_read_next   = '0;
              checksum_read_next = '0;
            end
          end
        end

        fssm_pkg::MODE_SCAN_DONE: begin
          byte_count_next    = '0;
          running_sum_next   = '0;
          key_match_next     = 1'b1;
          serial_read_next   = '0;
          checksum_read_next = '0;
          scan_pos_next      = '0;
          scan_mir_next      = '0;
          scan_done_next     = 1'b0;
          any_found_next     = 1'b0;
          push               = 1'b1;
          if (any_found) begin
            cmd.first = mk(fssm_pkg::ACT_READY, 1'b0, cur_mirror, cur_position,
                           cur_serial, 1'b1);
          end else begin
            // Nothing valid: format mirror 0, slot 0, serial 0
            cur_mirror_next      = '0;
            cur_position_next    = '0;
            cur_serial_next      = '0;
            target_mirror_next   = '0;
            target_position_next = '0;
            pending_next         = PEND_FORMAT;
            cmd.first  = mk(fssm_pkg::ACT_ERASE, 1'b0, '0, '0, 16'd0, 1'b0);
            cmd.second = mk(fssm_pkg::ACT_PROGRAM, 1'b0, '0, '0, 16'd0, 1'b1);
            cmd.pair   = 1'b1;
          end
        end

        fssm_pkg::MODE_SAVE: begin
          push = 1'b1;
          if (pending != PEND_NONE) begin
            cmd.first = mk(fssm_pkg::ACT_FAILED, 1'b0, cur_mirror, cur_position,
                           cur_serial, 1'b1);
          end else begin
            target_mirror_next   = nm;
            target_position_next = np;
            pending_next         = PEND_FIRST;
            if (np == '0) begin
              cmd.first  = mk(fssm_pkg::ACT_ERASE, 1'b0, nm, '0, serial_inc, 1'b0);
              cmd.second = mk(fssm_pkg::ACT_PROGRAM, 1'b0, nm, np, serial_inc, 1'b1);
              cmd.pair   = 1'b1;
            end else begin
              cmd.first = mk(fssm_pkg::ACT_PROGRAM, 1'b0, nm, np, serial_inc, 1'b1);
            end
          end
        end

        fssm_pkg::MODE_VERIFY: begin
          case (pending)
            PEND_NONE: begin
            end
            PEND_FORMAT: begin
              push         = 1'b1;
              pending_next = PEND_NONE;
              cmd.first = mk(item.program_ok ? fssm_pkg::ACT_SAVED : fssm_pkg::ACT_FAILED,
                             1'b0, cur_mirror, cur_position, cur_serial, 1'b1);
            end
            PEND_FIRST, PEND_RETRY: begin
              push = 1'b1;
              if (item.program_ok) begin
                // Commit the target slot
                cur_mirror_next   = target_mirror;
                cur_position_next = target_position;
                cur_serial_next   = serial_inc;
                pending_next      = PEND_NONE;
                cmd.first = mk(fssm_pkg::ACT_SAVED, 1'b0, target_mirror, target_position,
                               serial_inc, 1'b1);
              end else if (pending == PEND_FIRST) begin
                pending_next = PEND_RETRY;
                cmd.first  = mk(fssm_pkg::ACT_ERASE, 1'b0, target_mirror, '0,
                                serial_inc, 1'b0);
                cmd.second = mk(fssm_pkg::ACT_PROGRAM, 1'b0, target_mirror, target_position,
                                serial_inc, 1'b1);
                cmd.pair   = 1'b1;
              end else begin
                pending_next = PEND_NONE;
                cmd.first = mk(fssm_pkg::ACT_FAILED, 1'b0, cur_mirror, cur_position,
                               cur_serial, 1'b1);
              end
            end
            default: begin
            end
          endcase
        end

        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_sum     <= '0;
      key_match       <= 1'b1;
      serial_read     <= '0;
      checksum_read   <= '0;
      scan_pos        <= '0;
      scan_mir        <= '0;
      scan_done       <= 1'b0;
      any_found       <= 1'b0;
      cur_mirror      <= '0;
      cur_position    <= '0;
      cur_serial      <= '0;
      pending         <= PEND_NONE;
      target_mirror   <= '0;
      target_position <= '0;
    end else begin
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
      key_match       <= key_match_next;
      serial_read     <= serial_read_next;
      checksum_read   <= checksum_read_next;
      scan_pos        <= scan_pos_next;
      scan_mir        <= scan_mir_next;
      scan_done       <= scan_done_next;
      any_found       <= any_found_next;
      cur_mirror      <= cur_mirror_next;
      cur_position    <= cur_position_next;
      cur_serial      <= cur_serial_next;
      pending         <= pending_next;
      target_mirror   <= target_mirror_next;
      target_position <= target_position_next;
    end
  end

endmodule

// File: sv/fssm_queue.sv
module fssm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fssm_pkg::cmd_t cmd,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output fssm_pkg::cmd_t head
);

  localparam int PTRW = fssm_pkg::QPTR_W;
  localparam int CNTW = fssm_pkg::QCNT_W;
  localparam logic [PTRW-1:0] LAST_PTR = PTRW'(fssm_pkg::QUEUE_DEPTH - 1);

  fssm_pkg::cmd_t  entries [fssm_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign full     = (count == CNTW'(fssm_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/fssm_back.sv
module fssm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                nonempty,
  input  fssm_pkg::cmd_t      head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output fssm_pkg::out_item_t result
);

  logic second, second_next;
  logic xfer;

  // Walk the head command one result per transfer
  assign result_valid = nonempty;
  assign result       = second ? head.second : head.first;
  assign xfer         = nonempty && !result_stall;
  assign pop          = xfer && (second || !head.pair);

  always_comb begin
    second_next = second;
    if (xfer) second_next = !second && head.pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

endmodule

// File: sv/flash_save_slot_manager.sv
// Channel | Direction | Handshake                  | Payload
// item    | in        | item_valid / item_stall    | fssm_pkg::in_item_t  (mode, data_byte, program_ok)
// result  | out       | result_valid / result_stall | fssm_pkg::out_item_t (action .. last)
//
// One input item is taken per cycle while the command queue has room; all state work for the
// item (byte check, sum, slot selection, save rotation) finishes in that cycle.
// Results leave one per cycle from the queue head while result_stall is low; an item that causes two
// results holds the output for two transfers; unstalled, one-result items sustain one item per cycle.
// Synchronous active-high reset clears scan, selection and pending state and empties the queue.
// A stalled output fills the two-entry queue; item_stall then rises until a command drains.
module flash_save_slot_manager (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  fssm_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output fssm_pkg::out_item_t result
);

  logic           push;
  logic           pop;
  logic           full;
  logic           nonempty;
  fssm_pkg::cmd_t cmd;
  fssm_pkg::cmd_t head;

  // Front: classify each item, update scan and save state, build its command
  fssm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .cmd        (cmd)
  );

  // Queue: hold commands so the input side keeps moving while results wait
  fssm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd      (cmd),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  // Back: issue one result per transfer, advance through a pair before the pop
  fssm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (nonempty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A non-final result is always followed by the final one of the same command
  a_pair_follows : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=> result_valid && result.last)
    else $error("pair result missing");

  // The first of a pair is always an erase, and a program follows it
  a_erase_then_program : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last
      |-> result.action == fssm_pkg::ACT_ERASE)
    else $error("non-final result is not an erase");

  a_program_after_erase : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last
      |=> result.action == fssm_pkg::ACT_PROGRAM)
    else $error("erase not followed by program");

  // Only a slot check reports a valid slot
  a_valid_only_checked : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.slot_valid |-> result.action == fssm_pkg::ACT_CHECKED)
    else $error("slot_valid outside slot check");

  // Reset empties the queue
  a_reset_empty : assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("queue not empty after reset");

endmodule
